/* src/dq_pkg.sv */
package dq_pkg;

    localparam int DATA_W        = 32;
    localparam int DEPTH_DEFAULT = 32;

    // Operation codes carried in the mode field.
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [2:0] MODE_POP_BACK   = 3'd3;
    localparam logic [2:0] MODE_LIST       = 3'd4;

    // Status codes returned with every result.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]               mode;
        logic signed [DATA_W-1:0] value;
    } dq_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] element;
        logic [1:0]               status;
        logic                     last;
    } dq_result_t;

endpackage

/* src/dq_ram.sv */
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/double_ended_queue.sv */
// Channel  Ports                        Handshake
// -------  ---------------------------  -------------------------------------------
// command  start, busy, item            beat taken at a clock edge with start && !busy
// result   result_valid, result         beat shown for one cycle, always taken
//
// A push's result beat appears in the cycle after it is taken
// and busy stays low, so pushes can follow each other back to back.
// A pop holds busy while the slot read comes back from the
// single-port-read slot memory; its result beat then passes the result register.
// A listing reads one slot per cycle and holds busy while it reads the stored
// elements; each result beat passes the registered memory read and then the
// result register after its slot address goes to the memory.
// Reset clears the front pointer and the element count; the slot memory is not
// cleared, since only occupied slots are ever read. The receiver cannot stall.
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  dq_pkg::dq_item_t   item,
    output logic               result_valid,
    output dq_pkg::dq_result_t result
);

    import dq_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW:0]   DEPTH_W   = (IW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
    localparam logic [IW-1:0] DEPTH_M1  = IW'(DEPTH - 1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LIST  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          pend_last_reg, pend_last_next;
    logic          result_valid_reg, result_valid_next;
    dq_result_t    result_reg, result_next;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [IW-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic          accept;
    logic          is_full;
    logic          is_empty;
    logic [IW-1:0] cnt_lo;
    logic [IW-1:0] cnt_m1;
    logic [IW-1:0] back_free;
    logic [IW-1:0] back_used;
    logic [IW-1:0] front_prev;
    logic [IW-1:0] front_succ;
    logic [IW-1:0] list_pos;

    // Ring addition: both operands stay below DEPTH, so one subtract wraps it.
    function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                               input logic [IW-1:0] off);
        logic [IW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[IW-1:0];
    endfunction

    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign is_full  = (count_reg == DEPTH_CNT);
    assign is_empty = (count_reg == '0);

    // The count is below DEPTH wherever these offsets are used.
    assign cnt_lo     = IW'(count_reg);
    assign cnt_m1     = IW'(count_reg - CW'(1));
    assign back_free  = ring_add(front_reg, cnt_lo);
    assign back_used  = ring_add(front_reg, cnt_m1);
    assign front_prev = ring_add(front_reg, DEPTH_M1);
    assign front_succ = ring_add(front_reg, IW'(1));
    assign list_pos   = ring_add(front_reg, rd_idx_reg);

    always_comb
    begin
        state_next        = state_reg;
        front_next        = front_reg;
        count_next        = count_reg;
        rd_idx_next       = rd_idx_reg;
        pend_valid_next   = 1'b0;
        pend_last_next    = 1'b0;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        ram_we            = 1'b0;
        ram_waddr         = back_free;
        ram_raddr         = front_reg;

        // A slot read issued last cycle has its data on the memory output now.
        if (pend_valid_reg)
        begin
            result_valid_next = 1'b1;
            result_next = '{element: ram_rdata, status: STAT_OK, last: pend_last_reg};
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.mode)
                        MODE_PUSH_BACK, MODE_PUSH_FRONT:
                        begin
                            result_valid_next = 1'b1;
                            if (is_full)
                            begin
                                result_next = '{element: '0, status: STAT_FULL, last: 1'b1};
                            end
                            else
                            begin
                                ram_we = 1'b1;
                                if (item.mode == MODE_PUSH_FRONT)
                                begin
                                    ram_waddr  = front_prev;
                                    front_next = front_prev;
                                end
                                count_next  = count_reg + CW'(1);
                                result_next = '{element: '0, status: STAT_OK, last: 1'b1};
                            end
                        end
                        MODE_POP_FRONT, MODE_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                result_valid_next = 1'b1;
                                result_next = '{element: '0, status: STAT_EMPTY, last: 1'b1};
                            end
                            else
                            begin
                                if (item.mode == MODE_POP_FRONT)
                                begin
                                    ram_raddr  = front_reg;
                                    front_next = front_succ;
                                end
                                else
                                begin
                                    ram_raddr = back_used;
                                end
                                count_next      = count_reg - CW'(1);
                                pend_valid_next = 1'b1;
                                pend_last_next  = 1'b1;
                                state_next      = S_DRAIN;
                            end
                        end
                        MODE_LIST:
                        begin
                            if (is_empty)
                            begin
                                result_valid_next = 1'b1;
                                result_next = '{element: '0, status: STAT_EMPTY, last: 1'b1};
                            end
                            else
                            begin
                                ram_raddr       = front_reg;
                                pend_valid_next = 1'b1;
                                pend_last_next  = (cnt_m1 == '0);
                                rd_idx_next     = IW'(1);
                                state_next      = (cnt_m1 == '0) ? S_DRAIN : S_LIST;
                            end
                        end
                        default:
                        begin
                            // Unused codes are taken and ignored.
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                ram_raddr       = list_pos;
                pend_valid_next = 1'b1;
                pend_last_next  = (rd_idx_reg == cnt_m1);
                rd_idx_next     = rd_idx_reg + IW'(1);
                if (rd_idx_reg == cnt_m1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            front_reg        <= '0;
            count_reg        <= '0;
            rd_idx_reg       <= '0;
            pend_valid_reg   <= 1'b0;
            pend_last_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            front_reg        <= front_next;
            count_reg        <= count_next;
            rd_idx_reg       <= rd_idx_next;
            pend_valid_reg   <= pend_valid_next;
            pend_last_reg    <= pend_last_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    // The element count never goes past the ring size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("element count exceeds ring depth");

    // A slot read in flight always turns into a result beat on the next cycle.
    a_read_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |=> result_valid)
        else $error("slot read produced no result beat");

    // A push taken while full is answered with the full status and no state change.
    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_full && (item.mode == MODE_PUSH_BACK || item.mode == MODE_PUSH_FRONT))
        |=> (result_valid && result.status == STAT_FULL && $stable(count_reg)))
        else $error("push on full queue not flagged");

    // The last read of a pop or listing is always marked as the final beat.
    a_drain_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> (pend_valid_reg && pend_last_reg))
        else $error("drain state without final slot read");
`endif

endmodule

/* test/dq_checker.sv */
`timescale 1ns / 1ps

module dq_checker #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  dq_pkg::dq_item_t   item,
    input  logic               result_valid,
    input  dq_pkg::dq_result_t result,
    output int                 mismatch_count,
    output int                 beats_owed
);

    import dq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    // Shadow copy of the queue contents.
    logic signed [DATA_W-1:0] ring [DEPTH];
    logic [PTR_W-1:0]         head;
    int                       fill;
    dq_result_t               owed_beats [$];

    function automatic logic [PTR_W-1:0] ring_pos(input int offset);
        return PTR_W'((int'(head) + offset) % DEPTH);
    endfunction

    function automatic dq_result_t make_beat(input logic signed [DATA_W-1:0] element,
                                             input logic [1:0] status, input logic last);
        dq_result_t beat;
        beat.element = element;
        beat.status  = status;
        beat.last    = last;
        return beat;
    endfunction

    // Applies one command to the shadow queue and queues the beats it must produce.
    task automatic apply_command(input dq_item_t cmd);
        logic [PTR_W-1:0] pos;
        int               i;
        case (cmd.mode)
            MODE_PUSH_BACK, MODE_PUSH_FRONT:
            begin
                if (fill >= DEPTH)
                begin
                    owed_beats.push_back(make_beat('0, STAT_FULL, 1'b1));
                end
                else
                begin
                    if (cmd.mode == MODE_PUSH_BACK)
                    begin
                        pos = ring_pos(fill);
                    end
                    else
                    begin
                        pos  = ring_pos(DEPTH - 1);
                        head = pos;
                    end
                    ring[pos] = cmd.value;
                    fill++;
                    owed_beats.push_back(make_beat('0, STAT_OK, 1'b1));
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK:
            begin
                if (fill == 0)
                begin
                    owed_beats.push_back(make_beat('0, STAT_EMPTY, 1'b1));
                end
                else
                begin
                    if (cmd.mode == MODE_POP_FRONT)
                    begin
                        pos  = head;
                        head = ring_pos(1);
                    end
                    else
                    begin
                        pos = ring_pos(fill - 1);
                    end
                    fill--;
                    owed_beats.push_back(make_beat(ring[pos], STAT_OK, 1'b1));
                end
            end
            MODE_LIST:
            begin
                if (fill == 0)
                begin
                    owed_beats.push_back(make_beat('0, STAT_EMPTY, 1'b1));
                end
                else
                begin
                    for (i = 0; i < fill; i++)
                    begin
                        owed_beats.push_back(make_beat(ring[ring_pos(i)], STAT_OK,
                                                       (i + 1 == fill)));
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_beat(input dq_result_t got);
        dq_result_t want;
        if (owed_beats.size() == 0)
        begin
            $display("%0t: unexpected result beat element %0d status %0d last %0d",
                     $time, got.element, got.status, got.last);
            mismatch_count++;
        end
        else
        begin
            want = owed_beats.pop_front();
            if (got.element !== want.element)
            begin
                $display("%0t: element expected %0d got %0d", $time, want.element, got.element);
                mismatch_count++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                mismatch_count++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last expected %0d got %0d", $time, want.last, got.last);
                mismatch_count++;
            end
        end
    endtask

    // Result beats always belong to earlier commands, so they are checked
    // before the command taken at the same edge is applied.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head           = '0;
            fill           = 0;
            mismatch_count = 0;
            owed_beats.delete();
            beats_owed     = 0;
        end
        else
        begin
            if (result_valid === 1'b1)
            begin
                check_beat(result);
            end
            else if (result_valid !== 1'b0)
            begin
                $display("%0t: result_valid expected 0 or 1 got %b", $time, result_valid);
                mismatch_count++;
            end
            if (start && !busy)
            begin
                apply_command(item);
            end
            beats_owed = owed_beats.size();
        end
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import dq_pkg::*;

    // Mode codes five to seven are not operations; the block must ignore them.
    localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    dq_item_t   item;
    logic       result_valid;
    dq_result_t result;
    int         mismatch_count;
    int         beats_owed;

    // When set, the command side inserts random idle cycles before a beat.
    bit         gaps_on;

    double_ended_queue #(
        .DEPTH(DEPTH_DEFAULT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .result_valid(result_valid),
        .result      (result)
    );

    // The checker sees the same wires as the block and keeps its own picture
    // of the queue; this module only drives commands and reports the outcome.
    dq_checker #(
        .DEPTH(DEPTH_DEFAULT)
    ) checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result_valid  (result_valid),
        .result        (result),
        .mismatch_count(mismatch_count),
        .beats_owed    (beats_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Worst case is roughly every command being a full listing of 32 beats;
    // 221 commands of that kind take well under 0.2 ms, so 5 ms is ample.
    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    // Values near the edges of the signed range show up more often than a
    // flat draw would give them.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return {1'b1, {(DATA_W-1){1'b0}}};
            1:       return {1'b0, {(DATA_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Sends one command beat. The task is entered at a falling edge and
    // returns at the falling edge after the beat was taken, so start stays
    // high across back-to-back beats with a single assignment per edge.
    task automatic send_command(input logic [2:0] mode, input logic signed [DATA_W-1:0] value);
        while (gaps_on && $urandom_range(99) < 31)
        begin
            start <= 1'b0;
            item  <= '{mode: 3'($urandom), value: $urandom};
            @(negedge clk);
        end
        start <= 1'b1;
        item  <= '{mode: mode, value: value};
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // One random command. push_pct steers the mix toward filling or draining
    // the queue so that both the full and the empty corners are reached often.
    task automatic random_command(input int push_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < 4)
        begin
            send_command(3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)), pick_value());
        end
        else if (roll < 12)
        begin
            send_command(MODE_LIST, pick_value());
        end
        else if ($urandom_range(99) < push_pct)
        begin
            send_command($urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, pick_value());
        end
        else
        begin
            send_command($urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK, pick_value());
        end
    endtask

    initial
    begin
        int m;
        int n;

        rst_n   = 1'b0;
        start   = 1'b0;
        item    = '0;
        gaps_on = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. Everything on an empty queue first: a listing and
        // both pops must report the empty status.
        send_command(MODE_LIST, 0);
        send_command(MODE_POP_FRONT, 0);
        send_command(MODE_POP_BACK, 0);

        // Push at the front of an empty queue, then drain it from the back,
        // which leaves the front pointer where it was.
        send_command(MODE_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}});
        send_command(MODE_POP_BACK, 0);

        // Same single element round trip, drained from the front this time,
        // which moves the front pointer on.
        send_command(MODE_PUSH_BACK, {1'b0, {(DATA_W-1){1'b1}}});
        send_command(MODE_POP_FRONT, 0);

        // Mixed pushes at both ends with alternating bit patterns, then a listing.
        send_command(MODE_PUSH_BACK, -1);
        send_command(MODE_PUSH_FRONT, 0);
        send_command(MODE_PUSH_FRONT, 32'sh5555_5555);
        send_command(MODE_PUSH_BACK, 32'shAAAA_AAAA);
        send_command(MODE_LIST, 0);

        // Unused mode codes in the middle of a live queue must leave it alone.
        for (m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++)
        begin
            send_command(3'(m), pick_value());
        end

        send_command(MODE_POP_FRONT, 0);
        send_command(MODE_POP_BACK, 0);
        send_command(MODE_LIST, 0);
        send_command(MODE_POP_FRONT, 0);
        send_command(MODE_POP_BACK, 0);
        send_command(MODE_LIST, 0);

        // Random part in bursts. The first fill burst pushes well past the
        // depth, so dropped pushes on a full queue and 32-beat listings occur.
        for (n = 0; n < 60; n++)
        begin
            random_command(85);
        end

        // Drain burst with no idle cycles at all, which also keeps pops and
        // listings back to back against the busy signal.
        gaps_on = 1'b0;
        for (n = 0; n < 50; n++)
        begin
            random_command(15);
        end
        gaps_on = 1'b1;

        // Refill from near empty so the ring wraps in the other direction.
        for (n = 0; n < 50; n++)
        begin
            random_command(90);
        end

        // Balanced traffic hovering around the middle.
        for (n = 0; n < 40; n++)
        begin
            random_command(50);
        end

        start <= 1'b0;

        // Wait for every owed beat, then a little longer so that a stray beat
        // from the block still gets caught.
        while (beats_owed != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);

        if (mismatch_count == 0 && beats_owed == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* sim.f */
src/dq_pkg.sv
src/dq_ram.sv
src/double_ended_queue.sv
test/dq_checker.sv
test/testbench.sv
